// ----- src/trace_stream_frame_checker_macros.svh -----
// Assertion macros used by the trace stream frame checker assertion file (tsfc_checker.sv).
`ifndef TRACE_STREAM_FRAME_CHECKER_MACROS_SVH
`define TRACE_STREAM_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsfc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsfc assertion failed");

`endif

// ----- src/tsfc_pkg.sv -----
// Package: types, codes, constants and CRC helper of the trace stream frame checker.
package tsfc_pkg;

    localparam int MAX_ENTRIES_DEF = 512;
    localparam int FIXED_BYTES     = 101;
    localparam int ENTRY_BYTES     = 77;
    localparam int MIN_FRAME       = 4 + FIXED_BYTES + 4;

    localparam logic [31:0] CRC_POLY       = 32'hedb8_8320;
    localparam logic [31:0] CRC_ONES       = 32'hffff_ffff;
    localparam logic [31:0] FOOT_HEAD_WORD = 32'h4e50_4652;
    localparam logic [31:0] FOOT_TAIL_WORD = 32'h3044_4e45;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_TRACE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_HEADER     = 4'd1;
    localparam logic [3:0] ERR_TRUNCATED  = 4'd2;
    localparam logic [3:0] ERR_LENGTH     = 4'd3;
    localparam logic [3:0] ERR_CRC        = 4'd4;
    localparam logic [3:0] ERR_COUNT      = 4'd5;
    localparam logic [3:0] ERR_SIZE       = 4'd6;
    localparam logic [3:0] ERR_FOOT_MAGIC = 4'd7;
    localparam logic [3:0] ERR_FOOT_TOTAL = 4'd8;
    localparam logic [3:0] ERR_TRAILING   = 4'd9;
    localparam logic [3:0] ERR_OVERFLOW   = 4'd10;

    typedef struct packed {
        logic        valid;
        logic [1:0]  result_kind;
        logic [3:0]  error_code;
        logic [15:0] frame_bytes;
        logic [9:0]  frame_candidates;
        logic [63:0] total_events;
        logic [63:0] total_candidates;
    } t_result;

    // Reflected CRC-32, one byte.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // Header magic "RFPNAT00".
    function automatic logic [7:0] head_magic(input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0: ch = 8'h52;
            3'd1: ch = 8'h46;
            3'd2: ch = 8'h50;
            3'd3: ch = 8'h4e;
            3'd4: ch = 8'h41;
            3'd5: ch = 8'h54;
            default: ch = 8'h30;
        endcase
        return ch;
    endfunction

endpackage

// ----- src/tsfc_stream_if.sv -----
// Stream interfaces: input byte channel and result channel.
interface tsfc_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface tsfc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [3:0]  error_code;
    logic [15:0] frame_bytes;
    logic [9:0]  frame_candidates;
    logic [63:0] total_events;
    logic [63:0] total_candidates;

    modport source (output valid, output result_kind, output error_code, output frame_bytes,
                    output frame_candidates, output total_events, output total_candidates,
                    input ready);
    modport sink (input valid, input result_kind, input error_code, input frame_bytes,
                  input frame_candidates, input total_events, input total_candidates,
                  output ready);
endinterface

// ----- src/tsfc_parser.sv -----
// Stream parser: phase tracking, CRC, count and footer checks, result register.
module tsfc_parser import tsfc_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic       i_res_taken,
    output t_result    o_res
);

    localparam int MAX_FRAME = MIN_FRAME + MAX_ENTRIES * (4 + ENTRY_BYTES);
    localparam int LEN_W     = $clog2(MAX_FRAME + 1);
    localparam logic [15:0] MAX_CNT = 16'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PREFIX,
        PH_FRAME,
        PH_FOOTER,
        PH_TAIL,
        PH_DONE
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic [31:0]       r_word, n_word;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [31:0]       r_crc, n_crc;
    logic [31:0]       r_stored, n_stored;
    logic [15:0]       r_root, n_root;
    logic [15:0]       r_hist, n_hist;
    logic [15:0]       r_cand, n_cand;
    logic [63:0]       r_ev_total, n_ev_total;
    logic [63:0]       r_ca_total, n_ca_total;
    logic              r_mismatch, n_mismatch;
    logic              r_count_bad, n_count_bad;
    logic              r_size_bad, n_size_bad;
    logic              r_ovf, n_ovf;
    t_result           r_res, n_res;

    logic              do_fail, do_frame, do_trace;
    logic [3:0]        fail_code;
    logic              mism;
    logic [31:0]       word_in;
    logic [16:0]       sum_rh;
    logic [23:0]       want;
    logic [23:0]       have;
    logic [31:0]       len32;
    logic [7:0]        ev_byte, ca_byte;

    // Size, count and overflow flags settle long before the frame's last byte.
    always_comb begin
        sum_rh      = {1'b0, r_root} + {1'b0, r_hist};
        want        = {6'd0, sum_rh, 1'b0} + 24'(r_cand) * 24'(ENTRY_BYTES);
        have        = 24'(r_len) - 24'(MIN_FRAME);
        n_size_bad  = (have != want);
        n_count_bad = (r_root > MAX_CNT) || (r_hist > MAX_CNT) || (r_cand > MAX_CNT);
        n_ovf       = ({48'd0, r_cand} > ~r_ca_total);
    end

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_word     = r_word;
        n_len      = r_len;
        n_crc      = r_crc;
        n_stored   = r_stored;
        n_root     = r_root;
        n_hist     = r_hist;
        n_cand     = r_cand;
        n_ev_total = r_ev_total;
        n_ca_total = r_ca_total;
        n_mismatch = r_mismatch;
        n_res      = r_res;
        n_res.valid = r_res.valid && !i_res_taken;

        do_fail   = 1'b0;
        do_frame  = 1'b0;
        do_trace  = 1'b0;
        fail_code = ERR_NONE;
        mism      = 1'b0;
        word_in   = {i_data_byte, (r_idx == '0) ? 24'd0 : r_word[31:8]};
        len32     = 32'(r_len);
        ev_byte   = r_ev_total[{r_idx[2:0], 3'b000} +: 8];
        ca_byte   = r_ca_total[{r_idx[2:0], 3'b000} +: 8];

        if (i_step && r_phase != PH_DONE) begin
            if (i_req_type) begin
                if (r_phase == PH_TAIL) begin
                    do_trace = 1'b1;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_TRUNCATED;
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        mism       = r_mismatch || (i_data_byte != head_magic(r_idx[2:0]));
                        n_mismatch = mism;
                        n_idx      = r_idx + 1'b1;
                        if (r_idx == LEN_W'(7)) begin
                            if (mism) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_HEADER;
                            end else begin
                                n_phase = PH_PREFIX;
                                n_idx   = '0;
                            end
                        end
                    end
                    PH_PREFIX: begin
                        n_word = word_in;
                        n_crc  = crc32_byte((r_idx == '0) ? CRC_ONES : r_crc, i_data_byte);
                        n_idx  = r_idx + 1'b1;
                        if (r_idx == LEN_W'(3)) begin
                            if (word_in == FOOT_HEAD_WORD) begin
                                n_phase    = PH_FOOTER;
                                n_mismatch = 1'b0;
                            end else if (word_in < 32'(MIN_FRAME)
                                         || word_in > 32'(MAX_FRAME)) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_LENGTH;
                            end else begin
                                n_len   = word_in[LEN_W-1:0];
                                n_root  = '0;
                                n_hist  = '0;
                                n_cand  = '0;
                                n_phase = PH_FRAME;
                            end
                        end
                    end
                    PH_FRAME: begin
                        if (r_idx < r_len - LEN_W'(4)) begin
                            n_crc = crc32_byte(r_crc, i_data_byte);
                            if (r_idx == LEN_W'(75)) n_root = {r_root[15:8], i_data_byte};
                            if (r_idx == LEN_W'(76)) n_root = {i_data_byte, r_root[7:0]};
                            if (r_idx == LEN_W'(77)) n_hist = {r_hist[15:8], i_data_byte};
                            if (r_idx == LEN_W'(78)) n_hist = {i_data_byte, r_hist[7:0]};
                            if (r_idx == LEN_W'(79)) n_cand = {r_cand[15:8], i_data_byte};
                            if (r_idx == LEN_W'(80)) n_cand = {i_data_byte, r_cand[7:0]};
                        end else begin
                            n_stored = {i_data_byte, r_stored[31:8]};
                        end
                        if (r_idx == r_len - LEN_W'(1)) begin
                            do_fail = 1'b1;
                            if ((r_crc ^ CRC_ONES) != {i_data_byte, r_stored[31:8]}) begin
                                fail_code = ERR_CRC;
                            end else if (r_count_bad) begin
                                fail_code = ERR_COUNT;
                            end else if (r_size_bad) begin
                                fail_code = ERR_SIZE;
                            end else if (r_ovf) begin
                                fail_code = ERR_OVERFLOW;
                            end else begin
                                do_fail  = 1'b0;
                                do_frame = 1'b1;
                            end
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    PH_FOOTER: begin
                        if (r_idx < LEN_W'(8)) begin
                            n_word = {i_data_byte, r_word[31:8]};
                        end else if (r_idx < LEN_W'(16)) begin
                            n_mismatch = r_mismatch || (ev_byte != i_data_byte);
                        end else begin
                            n_mismatch = r_mismatch || (ca_byte != i_data_byte);
                        end
                        n_idx = r_idx + 1'b1;
                        if (r_idx == LEN_W'(23)) begin
                            if (r_word != FOOT_TAIL_WORD) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_FOOT_MAGIC;
                            end else if (n_mismatch) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_FOOT_TOTAL;
                            end else begin
                                n_phase = PH_TAIL;
                            end
                        end
                    end
                    PH_TAIL: begin
                        do_fail   = 1'b1;
                        fail_code = ERR_TRAILING;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (do_fail) begin
            n_phase = PH_DONE;
            n_res   = '{valid: 1'b1, result_kind: KIND_ERROR, error_code: fail_code,
                        frame_bytes: 16'd0, frame_candidates: 10'd0,
                        total_events: r_ev_total, total_candidates: r_ca_total};
        end else if (do_trace) begin
            n_phase = PH_DONE;
            n_res   = '{valid: 1'b1, result_kind: KIND_TRACE, error_code: ERR_NONE,
                        frame_bytes: 16'd0, frame_candidates: 10'd0,
                        total_events: r_ev_total, total_candidates: r_ca_total};
        end else if (do_frame) begin
            n_ev_total = r_ev_total + 64'd1;
            n_ca_total = r_ca_total + 64'(r_cand);
            n_phase    = PH_PREFIX;
            n_idx      = '0;
            n_res      = '{valid: 1'b1, result_kind: KIND_FRAME, error_code: ERR_NONE,
                           frame_bytes: len32[15:0], frame_candidates: r_cand[9:0],
                           total_events: n_ev_total, total_candidates: n_ca_total};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_idx       <= '0;
            r_mismatch  <= 1'b0;
            r_ev_total  <= '0;
            r_ca_total  <= '0;
            r_res.valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_mismatch <= n_mismatch;
            r_ev_total <= n_ev_total;
            r_ca_total <= n_ca_total;
            r_res      <= n_res;
        end
        r_word      <= n_word;
        r_len       <= n_len;
        r_crc       <= n_crc;
        r_stored    <= n_stored;
        r_root      <= n_root;
        r_hist      <= n_hist;
        r_cand      <= n_cand;
        r_count_bad <= n_count_bad;
        r_size_bad  <= n_size_bad;
        r_ovf       <= n_ovf;
    end

    assign o_res = r_res;

endmodule

// ----- src/trace_stream_frame_checker.sv -----
// Pipeline: the input beat that causes a result beat passes two registers
// (input register, then the parser's result register).
// Throughput: one input beat per cycle while result beats are taken; the result
// register and the input register each hold one beat under backpressure.
// Reset: synchronous, active low; clears phase, index, totals and valid flags.
module trace_stream_frame_checker import tsfc_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsfc_in_if.sink    i_in,
    tsfc_out_if.source o_out
);

    logic       r_in_valid, n_in_valid;
    logic       r_req_type;
    logic [7:0] r_data_byte;
    logic       out_free;
    logic       step;
    logic       in_ready;
    logic       in_fire;
    logic       res_taken;
    t_result    res;

    assign out_free  = !res.valid || o_out.ready;
    assign step      = r_in_valid && out_free;
    assign in_ready  = !r_in_valid || step;
    assign in_fire   = i_in.valid && in_ready;
    assign res_taken = res.valid && o_out.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (in_fire) begin
            r_req_type  <= i_in.req_type;
            r_data_byte <= i_in.data_byte;
        end
    end

    tsfc_parser #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_req_type  (r_req_type),
        .i_data_byte (r_data_byte),
        .i_res_taken (res_taken),
        .o_res       (res)
    );

    assign i_in.ready             = in_ready;
    assign o_out.valid            = res.valid;
    assign o_out.result_kind      = res.result_kind;
    assign o_out.error_code       = res.error_code;
    assign o_out.frame_bytes      = res.frame_bytes;
    assign o_out.frame_candidates = res.frame_candidates;
    assign o_out.total_events     = res.total_events;
    assign o_out.total_candidates = res.total_candidates;

endmodule

// ----- src/tsfc_checker.sv -----
// Port-level assertion checker for the trace stream frame checker, with its bind.
`include "trace_stream_frame_checker_macros.svh"

module tsfc_checker import tsfc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_result_kind,
    input logic [3:0]  i_error_code,
    input logic [15:0] i_frame_bytes,
    input logic [9:0]  i_frame_candidates,
    input logic [63:0] i_total_events,
    input logic [63:0] i_total_candidates
);

    // An error code comes with an error beat and only with one.
    `TSFC_ASSERT_IMP(a_code_kind, i_clk, i_rst_n, i_out_valid, ((i_result_kind == KIND_ERROR) == (i_error_code != ERR_NONE)))
    // Frame fields are zero outside frame beats.
    `TSFC_ASSERT_IMP(a_frame_fields, i_clk, i_rst_n, i_out_valid && (i_result_kind != KIND_FRAME), (i_frame_bytes == 16'd0) && (i_frame_candidates == 10'd0))
    // A final beat ends the stream: nothing follows it.
    `TSFC_ASSERT_NXT(a_final_beat, i_clk, i_rst_n, i_out_valid && i_out_ready && (i_result_kind != KIND_FRAME), !i_out_valid)
    // Hold a stalled result beat.
    `TSFC_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_result_kind) && $stable(i_total_events) && $stable(i_total_candidates))

endmodule

bind trace_stream_frame_checker tsfc_checker u_tsfc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_result_kind      (o_out.result_kind),
    .i_error_code       (o_out.error_code),
    .i_frame_bytes      (o_out.frame_bytes),
    .i_frame_candidates (o_out.frame_candidates),
    .i_total_events     (o_out.total_events),
    .i_total_candidates (o_out.total_candidates)
);

// ----- test/trace_stream_frame_checker_tb.sv -----
// Testbench of the trace stream frame checker: stream generator, predictor and result checks.
module trace_stream_frame_checker_tb;
    import tsfc_pkg::*;

    localparam int          ENTRY_LIMIT = MAX_ENTRIES_DEF;
    localparam int          MAX_LEN     = MIN_FRAME + ENTRY_LIMIT * (4 + ENTRY_BYTES);
    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam logic [63:0] TRACE_MAGIC = "RFPNAT00";

    typedef enum logic [2:0] {
        AT_HEADER, AT_PREFIX, IN_FRAME, IN_FOOTER, AT_TAIL, FINISHED
    } parse_phase_e;

    typedef enum int {
        END_CLEAN, END_TRAILING, END_BAD_TAIL_MAGIC, END_BAD_TOTALS, END_TRUNCATED,
        END_BAD_CRC, END_BAD_COUNT, END_BAD_SIZE, END_BAD_LENGTH, END_BAD_HEADER
    } run_ending_e;

    typedef struct {
        bit         eos;
        logic [7:0] data;
        bit         hold;
    } stream_beat_t;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  code;
        logic [15:0] f_bytes;
        logic [9:0]  f_cands;
        logic [63:0] tot_events;
        logic [63:0] tot_cands;
    } verdict_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsfc_in_if  in_ch();
    tsfc_out_if out_ch();

    trace_stream_frame_checker dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #10 i_clk = ~i_clk;

    stream_beat_t stream_q[$];
    verdict_t     verdict_q[$];
    int           fail_count  = 0;
    int           cycle_count = 0;

    // generator bookkeeping: totals of the frames that are meant to pass
    logic [63:0] gen_events = '0;
    logic [63:0] gen_cands  = '0;

    // predictor state
    parse_phase_e ph;
    int unsigned  sec_idx;
    logic [31:0]  pfx_word, frm_len, crc_acc, crc_rx;
    logic [15:0]  n_root, n_hist, n_cand;
    logic [63:0]  ev_total, cand_total;
    bit           mism;

    function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        int k;
        r = acc ^ {24'd0, b};
        for (k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic int unsigned frame_len_for(input int unsigned r, h, c);
        return MIN_FRAME + 2 * (r + h) + ENTRY_BYTES * c;
    endfunction

    task automatic post_verdict(input logic [1:0] kind, input logic [3:0] code,
                                input logic [15:0] fb, input logic [9:0] fc);
        verdict_q.push_back('{kind, code, fb, fc, ev_total, cand_total});
    endtask

    task automatic fail_stream(input logic [3:0] code);
        ph = FINISHED;
        post_verdict(KIND_ERROR, code, '0, '0);
    endtask

    task automatic close_frame();
        logic [63:0] have, want, r64, h64, c64;
        r64 = {48'd0, n_root};
        h64 = {48'd0, n_hist};
        c64 = {48'd0, n_cand};
        have = {32'd0, frm_len} - MIN_FRAME;
        want = (r64 + h64) * 2 + c64 * ENTRY_BYTES;
        if ((crc_acc ^ CRC_ONES) != crc_rx) begin
            fail_stream(ERR_CRC);
        end else if (n_root > ENTRY_LIMIT || n_hist > ENTRY_LIMIT || n_cand > ENTRY_LIMIT) begin
            fail_stream(ERR_COUNT);
        end else if (have != want) begin
            fail_stream(ERR_SIZE);
        end else if (c64 > ~cand_total) begin
            fail_stream(ERR_OVERFLOW);
        end else begin
            ev_total   = ev_total + 1;
            cand_total = cand_total + c64;
            ph         = AT_PREFIX;
            sec_idx    = 0;
            post_verdict(KIND_FRAME, ERR_NONE, frm_len[15:0], n_cand[9:0]);
        end
    endtask

    // Advance the parser by one accepted beat and queue the result it causes.
    task automatic track_beat(input logic eos, input logic [7:0] b);
        if (ph == FINISHED) return;
        if (eos) begin
            if (ph == AT_TAIL) begin
                ph = FINISHED;
                post_verdict(KIND_TRACE, ERR_NONE, '0, '0);
            end else begin
                fail_stream(ERR_TRUNCATED);
            end
            return;
        end
        case (ph)
            AT_HEADER: begin
                if (b != TRACE_MAGIC[8 * (7 - (sec_idx % 8)) +: 8]) mism = 1'b1;
                sec_idx++;
                if (sec_idx >= 8) begin
                    if (mism) begin
                        fail_stream(ERR_HEADER);
                    end else begin
                        ph      = AT_PREFIX;
                        sec_idx = 0;
                    end
                end
            end
            AT_PREFIX: begin
                if (sec_idx == 0) begin
                    crc_acc  = CRC_ONES;
                    pfx_word = '0;
                end
                pfx_word[8 * (sec_idx % 4) +: 8] = b;
                crc_acc = crc32_next(crc_acc, b);
                sec_idx++;
                if (sec_idx >= 4) begin
                    if (pfx_word == FOOT_HEAD_WORD) begin
                        ph       = IN_FOOTER;
                        pfx_word = '0;
                        mism     = 1'b0;
                    end else if (pfx_word < MIN_FRAME || pfx_word > MAX_LEN) begin
                        fail_stream(ERR_LENGTH);
                    end else begin
                        frm_len = pfx_word;
                        crc_rx  = '0;
                        n_root  = '0;
                        n_hist  = '0;
                        n_cand  = '0;
                        ph      = IN_FRAME;
                    end
                end
            end
            IN_FRAME: begin
                if (sec_idx < frm_len - 4) begin
                    crc_acc = crc32_next(crc_acc, b);
                    case (sec_idx)
                        75: n_root[7:0]  = b;
                        76: n_root[15:8] = b;
                        77: n_hist[7:0]  = b;
                        78: n_hist[15:8] = b;
                        79: n_cand[7:0]  = b;
                        80: n_cand[15:8] = b;
                        default: ;
                    endcase
                end else begin
                    crc_rx[8 * ((sec_idx - (frm_len - 4)) % 4) +: 8] = b;
                end
                if (sec_idx + 1 >= frm_len) close_frame();
                else sec_idx++;
            end
            IN_FOOTER: begin
                if (sec_idx < 8) pfx_word[8 * (sec_idx - 4) +: 8] = b;
                else if (sec_idx < 16) mism |= (ev_total[8 * (sec_idx - 8) +: 8] != b);
                else mism |= (cand_total[8 * (sec_idx - 16) +: 8] != b);
                sec_idx++;
                if (sec_idx >= 24) begin
                    if (pfx_word != FOOT_TAIL_WORD) fail_stream(ERR_FOOT_MAGIC);
                    else if (mism) fail_stream(ERR_FOOT_TOTAL);
                    else ph = AT_TAIL;
                end
            end
            default: fail_stream(ERR_TRAILING);
        endcase
    endtask

    task automatic push_beat(input bit eos, input logic [7:0] b, input bit hold);
        stream_q.push_back('{eos, b, hold});
    endtask

    task automatic add_header(input bit corrupt, input int cut);
        logic [7:0] b;
        int i, bad_at;
        bad_at = $urandom_range(0, 7);
        for (i = 0; i < cut; i++) begin
            b = TRACE_MAGIC[8 * (7 - i) +: 8];
            if (corrupt && i == bad_at) b ^= 8'h01 << $urandom_range(0, 7);
            push_beat(1'b0, b, 1'b0);
        end
    endtask

    // Build one frame with the given count fields and length; cut < 0 sends it whole.
    task automatic add_frame(input logic [15:0] n_r, n_h, n_c, input logic [31:0] len,
                             input bit bad_crc, input bit hold, input int cut);
        logic [7:0]  body[$];
        logic [7:0]  rb;
        logic [31:0] crc;
        int k;
        for (k = 0; k < 4; k++) body.push_back(len[8 * k +: 8]);
        while (body.size() < len - 4) begin
            rb = $urandom;
            body.push_back(rb);
        end
        body[75] = n_r[7:0];
        body[76] = n_r[15:8];
        body[77] = n_h[7:0];
        body[78] = n_h[15:8];
        body[79] = n_c[7:0];
        body[80] = n_c[15:8];
        crc = CRC_ONES;
        for (k = 0; k < body.size(); k++) crc = crc32_next(crc, body[k]);
        crc ^= CRC_ONES;
        if (bad_crc) crc ^= 32'd1 << $urandom_range(0, 31);
        for (k = 0; k < 4; k++) body.push_back(crc[8 * k +: 8]);
        for (k = 0; k < body.size() && (cut < 0 || k < cut); k++)
            push_beat(1'b0, body[k], hold && k == 0);
    endtask

    task automatic add_good_frame(input int unsigned r, h, c, input bit hold);
        add_frame(r, h, c, frame_len_for(r, h, c), 1'b0, hold, -1);
        gen_events = gen_events + 1;
        gen_cands  = gen_cands + c;
    endtask

    task automatic add_footer(input bit bad_tail, input bit bad_totals, input int cut,
                              input bit hold);
        logic [7:0] fb[24];
        int i, k;
        for (i = 0; i < 4; i++) begin
            fb[i]     = FOOT_HEAD_WORD[8 * i +: 8];
            fb[4 + i] = FOOT_TAIL_WORD[8 * i +: 8];
        end
        for (i = 0; i < 8; i++) begin
            fb[8 + i]  = gen_events[8 * i +: 8];
            fb[16 + i] = gen_cands[8 * i +: 8];
        end
        if (bad_tail) begin
            k = $urandom_range(4, 7);
            fb[k] ^= 8'h01 << $urandom_range(0, 7);
        end
        if (bad_totals) begin
            k = $urandom_range(8, 23);
            fb[k] ^= 8'h01 << $urandom_range(0, 7);
        end
        for (i = 0; i < cut; i++) push_beat(1'b0, fb[i], hold && i == 0);
    endtask

    // Driver: bursts of random length, random gaps, optional drain before held beats.
    int           burst_left, gap_left;
    stream_beat_t next_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.req_type  <= 1'b0;
            in_ch.data_byte <= 8'd0;
            burst_left      = 0;
            gap_left        = 0;
            ph              = AT_HEADER;
            sec_idx         = 0;
            pfx_word        = '0;
            frm_len         = '0;
            crc_acc         = CRC_ONES;
            crc_rx          = '0;
            n_root          = '0;
            n_hist          = '0;
            n_cand          = '0;
            ev_total        = '0;
            cand_total      = '0;
            mism            = 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) track_beat(in_ch.req_type, in_ch.data_byte);
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (stream_q.size() == 0 ||
                         (stream_q[0].hold && verdict_q.size() != 0)) begin
                in_ch.valid <= 1'b0;
            end else begin
                next_beat = stream_q.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.req_type  <= next_beat.eos;
                in_ch.data_byte <= next_beat.data;
                if (burst_left <= 1) begin
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(200, 2000);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = $urandom_range(0, 6);
                    end
                end else begin
                    burst_left--;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: compare result beats and stall the result channel on its own pattern.
    int       stall_mode, stall_span;
    verdict_t due;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_span   = 0;
            stall_mode   = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with none expected: kind %0d, code %0d",
                           out_ch.result_kind, out_ch.error_code);
                    fail_count++;
                end else begin
                    due = verdict_q.pop_front();
                    check_field("result_kind", due.kind, out_ch.result_kind);
                    check_field("error_code", due.code, out_ch.error_code);
                    check_field("frame_bytes", due.f_bytes, out_ch.frame_bytes);
                    check_field("frame_candidates", due.f_cands, out_ch.frame_candidates);
                    check_field("total_events", due.tot_events, out_ch.total_events);
                    check_field("total_candidates", due.tot_cands, out_ch.total_candidates);
                end
            end
            if (stall_span == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_span = (stall_mode == 3) ? $urandom_range(1, 40) : $urandom_range(20, 400);
            end
            stall_span--;
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= $urandom_range(0, 1);
                2: out_ch.ready <= ($urandom_range(0, 4) == 0);
                default: out_ch.ready <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[trace_stream_frame_checker] ERROR");
            $finish;
        end
    end

    initial begin
        run_ending_e ending;
        int          pick, way, start_size, n_frames, i, n;
        int unsigned r, h, c, big, base;
        logic [31:0] len;
        logic [7:0]  rb;

        in_ch.valid     = 1'b0;
        in_ch.req_type  = 1'b0;
        in_ch.data_byte = 8'd0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;

        // Each run ends the stream one way; the block then ignores input until reset.
        pick   = $urandom_range(0, 12);
        ending = (pick <= 3) ? END_CLEAN : run_ending_e'(pick - 3);
        way    = $urandom_range(0, 3);

        if (ending == END_BAD_HEADER) begin
            add_header(1'b1, 8);
        end else if (ending == END_TRUNCATED && way == 0) begin
            add_header(1'b0, $urandom_range(0, 8));
            rb = $urandom;
            push_beat(1'b1, rb, 1'b0);
        end else begin
            add_header(1'b0, 8);
            if (!(ending == END_CLEAN && $urandom_range(0, 15) == 0)) begin
                add_good_frame(0, 0, 0, 1'b0);
                add_good_frame(ENTRY_LIMIT, ENTRY_LIMIT, ENTRY_LIMIT, 1'b1);
                add_good_frame(1, 0, 0, 1'b0);
                add_good_frame(0, 1, 0, 1'b0);
                add_good_frame(0, 0, 1, 1'b1);

                start_size = stream_q.size();
                n_frames   = 0;
                while (stream_q.size() < start_size + 800 || n_frames < 40) begin
                    r = $urandom_range(0, 6);
                    h = $urandom_range(0, 6);
                    c = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 10) : $urandom_range(0, 2);
                    if ($urandom_range(0, 19) == 0) r = $urandom_range(256, ENTRY_LIMIT);
                    add_good_frame(r, h, c, $urandom_range(0, 5) == 0);
                    n_frames++;
                end
            end

            case (ending)
                END_CLEAN: begin
                    add_footer(1'b0, 1'b0, 24, 1'b1);
                    rb = $urandom;
                    push_beat(1'b1, rb, 1'b0);
                end
                END_TRAILING: begin
                    add_footer(1'b0, 1'b0, 24, 1'b0);
                    rb = $urandom;
                    push_beat(1'b0, rb, 1'b0);
                end
                END_BAD_TAIL_MAGIC: add_footer(1'b1, 1'b0, 24, 1'b0);
                END_BAD_TOTALS:     add_footer(1'b0, 1'b1, 24, 1'b0);
                END_TRUNCATED: begin
                    if (way == 2) begin
                        r = $urandom_range(0, 4);
                        c = $urandom_range(0, 2);
                        base = frame_len_for(r, 0, c);
                        add_frame(r, 0, c, base, 1'b0, 1'b0, $urandom_range(1, base - 1));
                    end else if (way == 3) begin
                        add_footer(1'b0, 1'b0, $urandom_range(1, 23), 1'b0);
                    end
                    rb = $urandom;
                    push_beat(1'b1, rb, 1'b0);
                end
                END_BAD_CRC: begin
                    r = $urandom_range(0, 4);
                    c = $urandom_range(0, 2);
                    add_frame(r, 0, c, frame_len_for(r, 0, c), 1'b1, 1'b0, -1);
                end
                END_BAD_COUNT: begin
                    pick = $urandom_range(0, 2);
                    big  = $urandom_range(0, 1) ? $urandom_range(ENTRY_LIMIT + 1, 700)
                                                : $urandom_range(ENTRY_LIMIT + 1, 65535);
                    if (pick != 2 && big <= 700) len = frame_len_for(big, 0, 0);
                    else len = frame_len_for(0, 0, 1);
                    add_frame(pick == 0 ? big : 0, pick == 1 ? big : 0, pick == 2 ? big : 0,
                              len, 1'b0, 1'b0, -1);
                end
                END_BAD_SIZE: begin
                    r    = $urandom_range(0, 4);
                    h    = $urandom_range(0, 4);
                    c    = $urandom_range(0, 2);
                    base = frame_len_for(r, h, c);
                    if (c > 0 && $urandom_range(0, 1)) len = base - $urandom_range(1, 76);
                    else len = base + $urandom_range(1, 76);
                    add_frame(r, h, c, len, 1'b0, 1'b0, -1);
                end
                END_BAD_LENGTH: begin
                    case ($urandom_range(0, 3))
                        0: len = $urandom_range(0, MIN_FRAME - 1);
                        1: len = $urandom_range(MAX_LEN + 1, 32'hffff_ffff);
                        2: begin
                            // "RFP" then anything but the last footer letter
                            rb = $urandom;
                            if (rb == FOOT_HEAD_WORD[31:24]) rb = rb + 8'd1;
                            len = {rb, FOOT_HEAD_WORD[23:0]};
                        end
                        default: len = $urandom_range(0, 1) ? MIN_FRAME - 1 : MAX_LEN + 1;
                    endcase
                    if (len == FOOT_HEAD_WORD) len = 32'hffff_ffff;
                    for (i = 0; i < 4; i++) push_beat(1'b0, len[8 * i +: 8], 1'b0);
                end
                default: ;
            endcase
        end

        // Tail of beats the finished block must ignore.
        n = $urandom_range(6, 20);
        for (i = 0; i < n; i++) begin
            rb = $urandom;
            push_beat(i == n - 1 || $urandom_range(0, 4) == 0, rb, 1'b0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stream_q.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("[trace_stream_frame_checker] OK");
        end else begin
            $display("[trace_stream_frame_checker] ERROR");
        end
        $finish;
    end

endmodule

// ----- trace_stream_frame_checker.f -----
+incdir+src
src/tsfc_pkg.sv
src/tsfc_stream_if.sv
src/tsfc_parser.sv
src/trace_stream_frame_checker.sv
src/tsfc_checker.sv
test/trace_stream_frame_checker_tb.sv
